FILE: design/plmc_pkg.sv
package plmc_pkg;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_D2P  = 2'd1;
  localparam logic [1:0] FUNC_P2D  = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  entry_index;
    logic [31:0] position;
    logic [31:0] distance;
  } plmc_cmd_t;

endpackage

FILE: design/plmc_ram.sv
module plmc_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: design/plmc_front.sv
// Front: accepts items into a two-entry queue.
module plmc_front import plmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  plmc_cmd_t cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output plmc_cmd_t cmd_o
);

  plmc_cmd_t  slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = slot_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    if (!push_i && pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= cmd_i;
  end

  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni) push_i |-> (!full_o || pop_i);
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

  property p_no_underflow;
    @(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o;
  endproperty
  a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

  property p_count;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3;
  endproperty
  a_count: assert property (p_count) else $error("bad count");

endmodule

FILE: design/plmc_back.sv
// Back: table writes, binary search, divide, saturate.
module plmc_back import plmc_pkg::*; #(
  parameter int Points = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  plmc_cmd_t   cmd_i,
  output logic        pop_o,
  input  logic [10:0] n_i,
  output logic        res_valid_o,
  output logic [31:0] position_o,
  output logic [31:0] distance_o,
  output logic [1:0]  status_o
);

  localparam int Aw = $clog2(Points);
  localparam int Nw = Aw + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_SWT  = 4'd2;
  localparam logic [3:0] S_SCMP = 4'd3;
  localparam logic [3:0] S_R0   = 4'd4;
  localparam logic [3:0] S_R1   = 4'd5;
  localparam logic [3:0] S_R1W  = 4'd6;
  localparam logic [3:0] S_PREP = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]  st_q, st_d;
  plmc_cmd_t   cmd_q;
  logic [Nw-1:0] n_q, first_q, last_q, mid;
  logic [Aw-1:0] raddr;
  logic [31:0] prd, drd;
  logic        bydist;
  logic signed [33:0] key, qry;
  logic signed [33:0] x0_q, y0_q, x1, y1;
  logic        neg_q;
  logic [32:0] mdy_q, mdq_q, mdx_q;
  logic [65:0] prod_q;
  logic [65:0] rem_q;
  logic [65:0] quo_q;
  logic [6:0]  cnt_q;
  logic        we;
  logic [66:0] trial;

  assign bydist = (cmd_q.func == FUNC_D2P);
  assign we = pop_o && (cmd_i.func == FUNC_LOAD) && (32'(cmd_i.entry_index) < 32'(Points));
  assign mid = Nw'((first_q + last_q) >> 1);

  always_comb begin
    raddr = mid[Aw-1:0];
    if (st_q == S_SCMP || st_q == S_R0) raddr = first_q[Aw-1:0];
    if (st_q == S_R1 || st_q == S_R1W) raddr = Aw'(first_q + Nw'(1));
  end

  plmc_ram #(.Width(32), .Depth(Points)) u_pos (
    .clk_i, .we_i(we), .waddr_i(Aw'(cmd_i.entry_index)),
    .wdata_i(cmd_i.position), .raddr_i(raddr), .rdata_o(prd));
  plmc_ram #(.Width(32), .Depth(Points)) u_dist (
    .clk_i, .we_i(we), .waddr_i(Aw'(cmd_i.entry_index)),
    .wdata_i(cmd_i.distance), .raddr_i(raddr), .rdata_o(drd));

  assign key = bydist ? {{2{drd[31]}}, drd} : {2'b00, prd};
  assign qry = bydist ? {{2{cmd_q.distance[31]}}, cmd_q.distance}
                      : {2'b00, cmd_q.position};
  assign x1  = key;
  assign y1  = bydist ? {2'b00, prd} : {{2{drd[31]}}, drd};
  assign trial = {rem_q, quo_q[65]} - {34'd0, mdx_q};

  logic signed [33:0] dy, dq, dx;
  assign dy = y1 - y0_q;
  assign dq = qry - x0_q;
  assign dx = x1 - x0_q;

  logic signed [67:0] res;
  logic [65:0] qv;
  assign qv = quo_q;
  assign res = neg_q ? ({{34{y0_q[33]}}, y0_q} - $signed({2'b00, qv}))
                     : ({{34{y0_q[33]}}, y0_q} + $signed({2'b00, qv}));

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE:  if (valid_i && (cmd_i.func == FUNC_D2P || cmd_i.func == FUNC_P2D)
                   && n_i >= 11'd2) st_d = S_SRCH;
      S_SRCH:  st_d = (last_q - first_q > Nw'(1)) ? S_SWT : S_SCMP;
      S_SWT:   st_d = S_SRCH;
      S_SCMP:  st_d = S_R0;
      S_R0:    st_d = S_R1;
      S_R1:    st_d = S_R1W;
      S_R1W:   st_d = S_PREP;
      S_PREP:  st_d = (dx == 34'sd0) ? S_IDLE : S_MUL;
      S_MUL:   st_d = S_DIV;
      S_DIV:   if (cnt_q == 7'd65) st_d = S_FIN;
      S_FIN:   st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  assign pop_o = (st_q == S_IDLE) && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      res_valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      res_valid_o <= (pop_o && !(st_d == S_SRCH)) || st_q == S_FIN
                     || (st_q == S_PREP && dx == 34'sd0);
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        cmd_q <= cmd_i;
        n_q <= (32'(n_i) > 32'(Points)) ? Nw'(Points) : Nw'(n_i);
        first_q <= '0;
        last_q <= (32'(n_i) > 32'(Points)) ? Nw'(Points) : Nw'(n_i);
        position_o <= '0;
        distance_o <= '0;
        status_o <= (cmd_i.func == FUNC_D2P || cmd_i.func == FUNC_P2D) && n_i < 11'd2
                    ? ST_FEW : ST_OK;
      end
      S_SWT: begin
        if (key < qry) first_q <= mid;
        else last_q <= mid;
      end
      S_SCMP: if (first_q > n_q - Nw'(2)) first_q <= n_q - Nw'(2);
      S_R1: begin
        x0_q <= key;
        y0_q <= bydist ? {2'b00, prd} : {{2{drd[31]}}, drd};
      end
      S_PREP: begin
        if (dx == 34'sd0) status_o <= ST_ZERO;
        neg_q <= ((dy < 0) != (dq < 0)) != (dx < 0);
        mdy_q <= 33'(dy < 0 ? -dy : dy);
        mdq_q <= 33'(dq < 0 ? -dq : dq);
        mdx_q <= 33'(dx < 0 ? -dx : dx);
      end
      S_MUL: begin
        quo_q <= mdy_q * mdq_q;
        rem_q <= '0;
        cnt_q <= '0;
      end
      S_DIV: begin
        if (!trial[66]) rem_q <= trial[65:0];
        else rem_q <= {rem_q[64:0], quo_q[65]};
        quo_q <= {quo_q[64:0], ~trial[66]};
        cnt_q <= cnt_q + 7'd1;
      end
      S_FIN: begin
        if (qv > 66'h100_0000_0000) begin
          status_o <= ST_SAT;
          if (bydist) position_o <= neg_q ? 32'd0 : 32'hFFFF_FFFF;
          else distance_o <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (bydist) begin
          if (res < 0) begin
            status_o <= ST_SAT; position_o <= 32'd0;
          end else if (res > 68'sh0_FFFF_FFFF) begin
            status_o <= ST_SAT; position_o <= 32'hFFFF_FFFF;
          end else position_o <= res[31:0];
        end else begin
          if (res < -68'sh8000_0000) begin
            status_o <= ST_SAT; distance_o <= 32'h8000_0000;
          end else if (res > 68'sh7FFF_FFFF) begin
            status_o <= ST_SAT; distance_o <= 32'h7FFF_FFFF;
          end else distance_o <= res[31:0];
        end
      end
      default: ;
    endcase
  end

  property p_pop_idle;
    @(posedge clk_i) disable iff (!rst_ni) pop_o |-> st_q == S_IDLE;
  endproperty
  a_pop_idle: assert property (p_pop_idle) else $error("pop outside idle");

  property p_fin_result;
    @(posedge clk_i) disable iff (!rst_ni) st_q == S_FIN |=> res_valid_o;
  endproperty
  a_fin_result: assert property (p_fin_result) else $error("missing result");

  property p_search_order;
    @(posedge clk_i) disable iff (!rst_ni) st_q == S_SRCH |-> first_q < last_q;
  endproperty
  a_search_order: assert property (p_search_order) else $error("search bounds");

endmodule

FILE: design/piecewise_linear_map_converter.sv
// Channel  | Dir | Handshake            | Payload
// command  | in  | start_i / busy_o     | func_i, entry_index_i, position_in_i, distance_in_i
// config   | in  | cfg_valid_i/cfg_ready_o | cfg_data_i (points_in_use)
// result   | out | done_o strobe        | position_out_o, distance_out_o, status_o
// Load, unused code and too-few-points items finish in the back end's idle state.
// Conversions: binary search, then clamp, table reads, prepare, multiply, 66-step divide and saturate.
// A two-item queue decouples the front from the back; busy_o is high when it is full.
// Reset clears control state only; the breakpoint tables are undefined until loaded.
// Results are a one-cycle strobe; the receiver cannot stall.
module piecewise_linear_map_converter import plmc_pkg::*; #(
  parameter int POINTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [9:0]  entry_index_i,
  input  logic [31:0] position_in_i,
  input  logic [31:0] distance_in_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i,
  output logic        done_o,
  output logic [31:0] position_out_o,
  output logic [31:0] distance_out_o,
  output logic [1:0]  status_o
);

  logic [10:0] n_q;
  logic        full, qvalid, pop;
  plmc_cmd_t   cmd_in, cmd_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o = full;
  assign cmd_in = '{func: func_i, entry_index: entry_index_i,
                    position: position_in_i, distance: distance_in_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) n_q <= '0;
    else if (cfg_valid_i) n_q <= cfg_data_i;
  end

  plmc_front u_front (
    .clk_i, .rst_ni, .push_i(start_i && !full), .cmd_i(cmd_in), .full_o(full),
    .pop_i(pop), .valid_o(qvalid), .cmd_o(cmd_q));

  plmc_back #(.Points(POINTS)) u_back (
    .clk_i, .rst_ni, .valid_i(qvalid), .cmd_i(cmd_q), .pop_o(pop), .n_i(n_q),
    .res_valid_o(done_o), .position_o(position_out_o), .distance_o(distance_out_o),
    .status_o);

endmodule
